// File: hdl/plbu_pkg.sv
// shared constants, types and saturation helpers for the price ladder book updater
package plbu_pkg;

   localparam int LADDER_DEPTH  = 65536;
   localparam int WINDOW_LENGTH = 100;
   localparam int QTY_WIDTH     = 40;

   localparam int IDX_WIDTH       = $clog2(LADDER_DEPTH);
   localparam int PRICE_WIDTH     = 32;
   localparam int IN_QTY_WIDTH    = 40;
   localparam int THR_WIDTH       = 40;
   localparam int MSG_WIDTH       = 48;
   localparam int CMP_WIDTH       = 48;
   localparam int LEVEL_WIDTH     = 16;
   localparam int EVQ_WIDTH       = 40;
   localparam int OUT_TOTAL_WIDTH = 55;
   localparam int RING_AW         = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
   localparam int FILL_WIDTH      = $clog2(WINDOW_LENGTH + 1);
   localparam int TOTAL_WIDTH     = MSG_WIDTH + $clog2(WINDOW_LENGTH);

   localparam int REQ_TDATA_WIDTH = 80;
   localparam int RSP_TDATA_WIDTH = 200;
   localparam int CSR_ADDR_WIDTH  = 4;
   localparam int CSR_DATA_WIDTH  = 64;

   localparam logic [PRICE_WIDTH-1:0] BASE_RESET      = 32'd4400000;
   localparam logic [THR_WIDTH-1:0]   THRESHOLD_RESET = 40'd500000000;

   localparam logic [63:0] QTY_MAX64   = (64'd1 << QTY_WIDTH) - 64'd1;
   localparam logic [63:0] TOTAL_MAX64 = (64'd1 << OUT_TOTAL_WIDTH) - 64'd1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LEVEL,
      ST_STEP
   } state_type;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_APPEAR  = 2'd1,
      EV_GONE    = 2'd2,
      EV_DROPPED = 2'd3
   } wall_event_type;

   typedef enum logic {
      KIND_LEVEL = 1'b0,
      KIND_END   = 1'b1
   } kind_type;

   typedef enum logic {
      REG_BASE      = 1'b0,
      REG_THRESHOLD = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [PRICE_WIDTH-1:0] base_price_ticks;
      logic [THR_WIDTH-1:0]   wall_threshold;
   } cfg_type;

   typedef struct packed {
      logic start;
      logic commit;
   } window_ctl_type;

   function automatic logic [QTY_WIDTH-1:0] sat_qty(input logic [IN_QTY_WIDTH-1:0] q);
      logic [63:0] q64;
      q64 = 64'(q);
      if (q64 > QTY_MAX64) return '1;
      return QTY_WIDTH'(q64);
   endfunction

   function automatic logic [MSG_WIDTH-1:0] sat_msg_add(input logic [MSG_WIDTH-1:0] a,
                                                        input logic [QTY_WIDTH-1:0] d);
      logic [MSG_WIDTH:0] s;
      s = (MSG_WIDTH+1)'(a) + (MSG_WIDTH+1)'(d);
      if (s[MSG_WIDTH]) return '1;
      return s[MSG_WIDTH-1:0];
   endfunction

   function automatic logic [OUT_TOTAL_WIDTH-1:0] sat_total(input logic [TOTAL_WIDTH-1:0] t);
      logic [63:0] t64;
      t64 = 64'(t);
      if (t64 > TOTAL_MAX64) return '1;
      return OUT_TOTAL_WIDTH'(t64);
   endfunction

endpackage

// File: hdl/plbu_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module plbu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/plbu_csr.sv
// configuration registers behind the apb-style port
module plbu_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [plbu_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [plbu_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [plbu_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready,
   output plbu_pkg::cfg_type                   cfg
);

   logic [plbu_pkg::PRICE_WIDTH-1:0] base_ff, base_in;
   logic [plbu_pkg::THR_WIDTH-1:0]   thr_ff, thr_in;
   plbu_pkg::reg_index_type          reg_sel;
   logic                             wr_strobe;

   // registers sit on 8-byte strides
   assign reg_sel   = plbu_pkg::reg_index_type'(csr_paddr[3]);
   assign wr_strobe = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      base_in = base_ff;
      thr_in  = thr_ff;
      if (wr_strobe) begin
         case (reg_sel)
            plbu_pkg::REG_BASE: begin
               base_in = csr_pwdata[plbu_pkg::PRICE_WIDTH-1:0];
            end
            plbu_pkg::REG_THRESHOLD: begin
               thr_in = csr_pwdata[plbu_pkg::THR_WIDTH-1:0];
            end
            default: begin
               base_in = base_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         plbu_pkg::REG_BASE:      csr_prdata = plbu_pkg::CSR_DATA_WIDTH'(base_ff);
         plbu_pkg::REG_THRESHOLD: csr_prdata = plbu_pkg::CSR_DATA_WIDTH'(thr_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= plbu_pkg::BASE_RESET;
         thr_ff  <= plbu_pkg::THRESHOLD_RESET;
      end else begin
         base_ff <= base_in;
         thr_ff  <= thr_in;
      end
   end

   assign cfg.base_price_ticks = base_ff;
   assign cfg.wall_threshold   = thr_ff;

endmodule

// File: hdl/plbu_window.sv
// sliding window of per-message aggressive volumes held in a ring memory
module plbu_window (
   input  logic                                 clock,
   input  logic                                 reset,
   input  plbu_pkg::window_ctl_type             ctl,
   input  logic [plbu_pkg::MSG_WIDTH-1:0]       msg_buy,
   input  logic [plbu_pkg::MSG_WIDTH-1:0]       msg_sell,
   output logic [plbu_pkg::OUT_TOTAL_WIDTH-1:0] buy_total,
   output logic [plbu_pkg::OUT_TOTAL_WIDTH-1:0] sell_total
);

   localparam int MW = plbu_pkg::MSG_WIDTH;
   localparam int TW = plbu_pkg::TOTAL_WIDTH;

   logic [plbu_pkg::RING_AW-1:0]    wp_ff, wp_in;
   logic [plbu_pkg::FILL_WIDTH-1:0] fill_ff, fill_in;
   logic [TW-1:0]                   buy_ff, buy_in;
   logic [TW-1:0]                   sell_ff, sell_in;
   logic [2*MW-1:0]                 ring_rd;
   logic [MW-1:0]                   old_buy, old_sell;
   logic                            full;

   plbu_ram #(
      .WIDTH (2*MW),
      .DEPTH (plbu_pkg::WINDOW_LENGTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ctl.commit),
      .wr_addr (wp_ff),
      .wr_data ({msg_sell, msg_buy}),
      .rd_en   (ctl.start),
      .rd_addr (wp_ff),
      .rd_data (ring_rd)
   );

   assign full = (fill_ff == plbu_pkg::FILL_WIDTH'(plbu_pkg::WINDOW_LENGTH));

   // the slot about to be overwritten holds the oldest message once the ring is full
   assign old_buy  = full ? ring_rd[MW-1:0]    : '0;
   assign old_sell = full ? ring_rd[2*MW-1:MW] : '0;

   always_comb begin
      wp_in   = wp_ff;
      fill_in = fill_ff;
      buy_in  = buy_ff;
      sell_in = sell_ff;
      if (ctl.commit) begin
         buy_in  = buy_ff - TW'(old_buy) + TW'(msg_buy);
         sell_in = sell_ff - TW'(old_sell) + TW'(msg_sell);
         if (!full) begin
            fill_in = fill_ff + 1'b1;
         end
         if (wp_ff == plbu_pkg::RING_AW'(plbu_pkg::WINDOW_LENGTH - 1)) begin
            wp_in = '0;
         end else begin
            wp_in = wp_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         fill_ff <= '0;
         buy_ff  <= '0;
         sell_ff <= '0;
      end else begin
         wp_ff   <= wp_in;
         fill_ff <= fill_in;
         buy_ff  <= buy_in;
         sell_ff <= sell_in;
      end
   end

   assign buy_total  = plbu_pkg::sat_total(buy_ff);
   assign sell_total = plbu_pkg::sat_total(sell_ff);

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= plbu_pkg::FILL_WIDTH'(plbu_pkg::WINDOW_LENGTH))
      else $error("ring fill count beyond window length");

   a_wp_in_ring: assert property (@(posedge clock) disable iff (reset)
      wp_ff <= plbu_pkg::RING_AW'(plbu_pkg::WINDOW_LENGTH - 1))
      else $error("ring write pointer outside the ring");

   a_start_commit_apart: assert property (@(posedge clock) disable iff (reset)
      ctl.start |=> ctl.start == 1'b0)
      else $error("window step started twice in a row");

endmodule

// File: hdl/price_ladder_book_updater_unit.sv
// price ladder book updater: bid/ask ladders, wall events and aggressive-flow window
// a result beat is registered from the modify state that follows its input beat's accept
// items do not overlap: accept with ladder or ring read, then modify and write back
// a stalled result beat holds the next item in its modify cycle until the beat is taken
// reset: synchronous; afterwards both ladders are cleared one entry per cycle, all LADDER_DEPTH
// entries (65536), while req_tready stays low; configuration writes are taken throughout
module price_ladder_book_updater_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [plbu_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,  // side, price_ticks, quantity
   input  logic                                 req_tuser,  // kind
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [plbu_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,  // event_side, level_index,
                                                            // event_quantity, best_bid_index,
                                                            // best_ask_index, buy_window_total,
                                                            // sell_window_total
   output logic [1:0]                           rsp_tuser,  // wall_event
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [plbu_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [plbu_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [plbu_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                 csr_pready
);

   localparam int IW = plbu_pkg::IDX_WIDTH;
   localparam int QW = plbu_pkg::QTY_WIDTH;
   localparam int MW = plbu_pkg::MSG_WIDTH;
   localparam int CW = plbu_pkg::CMP_WIDTH;

   plbu_pkg::cfg_type        cfg;
   plbu_pkg::window_ctl_type win_ctl;
   plbu_pkg::state_type      state_ff, state_in;

   // input beat fields
   plbu_pkg::kind_type                 req_kind;
   logic                               req_side;
   logic [plbu_pkg::PRICE_WIDTH-1:0]   req_price;
   logic [plbu_pkg::IN_QTY_WIDTH-1:0]  req_qty;
   logic [plbu_pkg::PRICE_WIDTH:0]     offset;
   logic                               in_range;
   logic                               accept;

   // item held between accept and modify
   logic          side_ff, side_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [QW-1:0] qty_ff, qty_in;
   logic          range_ff, range_in;

   logic [IW-1:0] clr_ff, clr_in;
   logic [IW-1:0] best_bid_ff, best_bid_in;
   logic [IW-1:0] best_ask_ff, best_ask_in;
   logic [MW-1:0] msg_buy_ff, msg_buy_in;
   logic [MW-1:0] msg_sell_ff, msg_sell_in;

   // volume drop applied in the cycle after the ladder write
   logic          pend_valid_ff, pend_valid_in;
   logic          pend_side_ff, pend_side_in;
   logic [QW-1:0] pend_diff_ff, pend_diff_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   plbu_pkg::wall_event_type            rsp_event_ff, rsp_event_in;
   logic                                rsp_side_ff, rsp_side_in;
   logic [plbu_pkg::LEVEL_WIDTH-1:0]    rsp_level_ff, rsp_level_in;
   logic [plbu_pkg::EVQ_WIDTH-1:0]      rsp_evq_ff, rsp_evq_in;

   logic [QW-1:0] bid_rd, ask_rd, prev;
   logic [CW-1:0] q_ext, p_ext, t_ext;
   logic          slot_free;
   logic          level_commit;
   logic          clearing;
   logic          bid_wr, ask_wr;
   logic [IW-1:0] lad_wr_addr;
   logic [QW-1:0] lad_wr_data;
   logic          lad_rd;
   logic [plbu_pkg::OUT_TOTAL_WIDTH-1:0] buy_total, sell_total;

   plbu_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign req_kind  = plbu_pkg::kind_type'(req_tuser);
   assign req_side  = req_tdata[0];
   assign req_price = req_tdata[32:1];
   assign req_qty   = req_tdata[72:33];

   // borrow out of the subtract means the price lies below the base
   assign offset   = {1'b0, req_price} - {1'b0, cfg.base_price_ticks};
   assign in_range = !offset[plbu_pkg::PRICE_WIDTH] &&
                     (offset[plbu_pkg::PRICE_WIDTH-1:0] <
                      plbu_pkg::PRICE_WIDTH'(plbu_pkg::LADDER_DEPTH));

   assign req_tready = (state_ff == plbu_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign clearing   = (state_ff == plbu_pkg::ST_CLEAR);
   assign level_commit = (state_ff == plbu_pkg::ST_LEVEL) && slot_free;

   assign lad_rd      = accept && (req_kind == plbu_pkg::KIND_LEVEL);
   assign bid_wr      = clearing || (level_commit && range_ff && side_ff);
   assign ask_wr      = clearing || (level_commit && range_ff && !side_ff);
   assign lad_wr_addr = clearing ? clr_ff : idx_ff;
   assign lad_wr_data = clearing ? '0 : qty_ff;

   plbu_ram #(
      .WIDTH (QW),
      .DEPTH (plbu_pkg::LADDER_DEPTH)
   ) u_bid_ladder (
      .clock   (clock),
      .wr_en   (bid_wr),
      .wr_addr (lad_wr_addr),
      .wr_data (lad_wr_data),
      .rd_en   (lad_rd),
      .rd_addr (offset[IW-1:0]),
      .rd_data (bid_rd)
   );

   plbu_ram #(
      .WIDTH (QW),
      .DEPTH (plbu_pkg::LADDER_DEPTH)
   ) u_ask_ladder (
      .clock   (clock),
      .wr_en   (ask_wr),
      .wr_addr (lad_wr_addr),
      .wr_data (lad_wr_data),
      .rd_en   (lad_rd),
      .rd_addr (offset[IW-1:0]),
      .rd_data (ask_rd)
   );

   assign win_ctl.start  = accept && (req_kind == plbu_pkg::KIND_END);
   assign win_ctl.commit = (state_ff == plbu_pkg::ST_STEP) && slot_free;

   plbu_window u_window (
      .clock      (clock),
      .reset      (reset),
      .ctl        (win_ctl),
      .msg_buy    (msg_buy_ff),
      .msg_sell   (msg_sell_ff),
      .buy_total  (buy_total),
      .sell_total (sell_total)
   );

   assign prev  = side_ff ? bid_rd : ask_rd;
   assign q_ext = CW'(qty_ff);
   assign p_ext = CW'(prev);
   assign t_ext = CW'(cfg.wall_threshold);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      side_in       = side_ff;
      idx_in        = idx_ff;
      qty_in        = qty_ff;
      range_in      = range_ff;
      best_bid_in   = best_bid_ff;
      best_ask_in   = best_ask_ff;
      msg_buy_in    = msg_buy_ff;
      msg_sell_in   = msg_sell_ff;
      pend_valid_in = 1'b0;
      pend_side_in  = pend_side_ff;
      pend_diff_in  = pend_diff_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_event_in  = rsp_event_ff;
      rsp_side_in   = rsp_side_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_evq_in    = rsp_evq_ff;

      if (pend_valid_ff) begin
         if (pend_side_ff) begin
            msg_sell_in = plbu_pkg::sat_msg_add(msg_sell_ff, pend_diff_ff);
         end else begin
            msg_buy_in = plbu_pkg::sat_msg_add(msg_buy_ff, pend_diff_ff);
         end
      end

      case (state_ff)
         plbu_pkg::ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == IW'(plbu_pkg::LADDER_DEPTH - 1)) begin
               state_in = plbu_pkg::ST_IDLE;
            end
         end
         plbu_pkg::ST_IDLE: begin
            if (accept) begin
               side_in  = req_side;
               idx_in   = offset[IW-1:0];
               qty_in   = plbu_pkg::sat_qty(req_qty);
               range_in = in_range;
               if (req_kind == plbu_pkg::KIND_END) begin
                  state_in = plbu_pkg::ST_STEP;
               end else begin
                  state_in = plbu_pkg::ST_LEVEL;
               end
            end
         end
         plbu_pkg::ST_LEVEL: begin
            if (slot_free) begin
               state_in     = plbu_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_side_in  = side_ff;
               rsp_event_in = plbu_pkg::EV_NONE;
               rsp_level_in = '0;
               rsp_evq_in   = '0;
               if (!range_ff) begin
                  rsp_event_in = plbu_pkg::EV_DROPPED;
               end else begin
                  rsp_level_in = plbu_pkg::LEVEL_WIDTH'(idx_ff);
                  if (side_ff && (qty_ff != '0) && (idx_ff > best_bid_ff)) begin
                     best_bid_in = idx_ff;
                  end
                  if (!side_ff && (qty_ff != '0) && (idx_ff < best_ask_ff)) begin
                     best_ask_in = idx_ff;
                  end
                  if (qty_ff < prev) begin
                     pend_valid_in = 1'b1;
                     pend_side_in  = side_ff;
                     pend_diff_in  = prev - qty_ff;
                  end
                  if ((q_ext >= t_ext) && (p_ext < t_ext)) begin
                     rsp_event_in = plbu_pkg::EV_APPEAR;
                     rsp_evq_in   = plbu_pkg::EVQ_WIDTH'(qty_ff);
                  end else if ((p_ext >= t_ext) && (q_ext < t_ext)) begin
                     rsp_event_in = plbu_pkg::EV_GONE;
                     rsp_evq_in   = plbu_pkg::EVQ_WIDTH'(prev);
                  end
               end
            end
         end
         plbu_pkg::ST_STEP: begin
            if (slot_free) begin
               state_in     = plbu_pkg::ST_IDLE;
               msg_buy_in   = '0;
               msg_sell_in  = '0;
               rsp_valid_in = 1'b1;
               rsp_event_in = plbu_pkg::EV_NONE;
               rsp_side_in  = 1'b0;
               rsp_level_in = '0;
               rsp_evq_in   = '0;
            end
         end
         default: begin
            state_in = plbu_pkg::ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= plbu_pkg::ST_CLEAR;
         clr_ff        <= '0;
         best_bid_ff   <= '0;
         best_ask_ff   <= IW'(plbu_pkg::LADDER_DEPTH - 1);
         msg_buy_ff    <= '0;
         msg_sell_ff   <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         best_bid_ff   <= best_bid_in;
         best_ask_ff   <= best_ask_in;
         msg_buy_ff    <= msg_buy_in;
         msg_sell_ff   <= msg_sell_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      side_ff      <= side_in;
      idx_ff       <= idx_in;
      qty_ff       <= qty_in;
      range_ff     <= range_in;
      pend_side_ff <= pend_side_in;
      pend_diff_ff <= pend_diff_in;
      rsp_event_ff <= rsp_event_in;
      rsp_side_ff  <= rsp_side_in;
      rsp_level_ff <= rsp_level_in;
      rsp_evq_ff   <= rsp_evq_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_event_ff;
   assign rsp_tdata  = {1'b0,
                        sell_total,
                        buy_total,
                        plbu_pkg::LEVEL_WIDTH'(best_ask_ff),
                        plbu_pkg::LEVEL_WIDTH'(best_bid_ff),
                        rsp_evq_ff,
                        rsp_level_ff,
                        rsp_side_ff};

   a_bid_only_rises: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> best_bid_ff >= $past(best_bid_ff))
      else $error("best bid index moved down");

   a_ask_only_falls: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> best_ask_ff <= $past(best_ask_ff))
      else $error("best ask index moved up");

   a_pending_before_step: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> state_ff == plbu_pkg::ST_IDLE)
      else $error("volume drop pending while the window step runs");

   a_no_write_while_busy_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !(bid_wr || ask_wr) || clearing)
      else $error("ladder written while the result beat is stalled");

endmodule
